@@ sv/spi_pkg.sv @@
// Shared types and constants for the segment pair intersection block.
`default_nettype none
package spi_pkg;

  localparam int FIELD_W        = 32;
  localparam int COORD_BITS_DEF = 32;
  localparam int NUM_COORDS     = 8;

  typedef struct packed {
    logic signed [FIELD_W-1:0] a_start_x;
    logic signed [FIELD_W-1:0] a_start_y;
    logic signed [FIELD_W-1:0] a_end_x;
    logic signed [FIELD_W-1:0] a_end_y;
    logic signed [FIELD_W-1:0] b_start_x;
    logic signed [FIELD_W-1:0] b_start_y;
    logic signed [FIELD_W-1:0] b_end_x;
    logic signed [FIELD_W-1:0] b_end_y;
  } spi_in_t;

  typedef struct packed {
    logic                      hit;
    logic signed [FIELD_W-1:0] cross_x;
    logic signed [FIELD_W-1:0] cross_y;
  } spi_out_t;

endpackage
`default_nettype wire

@@ sv/segment_pair_intersection.sv @@
// Top level of the segment pair intersection block.
`default_nettype none
// Usage
// An item is two segments, presented on item while start is high. It is
// taken at each rising edge where start is high and busy is low; busy is
// only high while rst is asserted, so one beat may be offered every cycle.
// Each item produces exactly one result beat on result, marked by done for
// a single cycle. The receiver cannot stall the block and must take every
// beat as it appears.
// Between the accepting edge and done lie the registers of the restoring
// divider, which resolves one quotient bit per stage over the full numerator
// width, plus six front stages for the cross products and two back stages
// for rounding and the box test. Throughput is one item per cycle.
// A synchronous reset clears every valid bit, so items in flight at reset
// are dropped and no result beat appears for them. Data registers are not
// reset. Coordinates are taken from the low COORD_BITS bits of each field.
module segment_pair_intersection #(
  parameter int COORD_BITS = spi_pkg::COORD_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire spi_pkg::spi_in_t item,
  output logic                  done,
  output spi_pkg::spi_out_t     result
);
  import spi_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int NW  = 3 * C + 3;
  localparam int DW  = 2 * C + 3;
  localparam int SW  = 8 * C + 3;
  localparam int LAT = NW + 8;
  localparam int CNT_W = $clog2(LAT + 1);

  logic          accept;
  logic          f_valid, d_valid;
  logic [NW-1:0] f_num [2];
  logic [DW-1:0] f_den [2];
  logic [SW-1:0] f_sb, d_sb;
  logic [NW-1:0] d_quo [2];
  logic [DW-1:0] d_rem [2];
  logic [DW-1:0] d_dvs [2];

  // The pipeline never holds off; it only refuses beats during reset.
  assign busy   = rst;
  assign accept = start && !busy;

  spi_front #(.C(C)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .item     (item),
    .out_valid(f_valid),
    .mag_n    (f_num),
    .mag_d    (f_den),
    .sb       (f_sb)
  );

  spi_div2 #(.NW(NW), .DW(DW), .SW(SW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .num      (f_num),
    .den      (f_den),
    .in_sb    (f_sb),
    .out_valid(d_valid),
    .quo      (d_quo),
    .rem      (d_rem),
    .dvs      (d_dvs),
    .out_sb   (d_sb)
  );

  spi_back #(.C(C)) u_back (
    .clk     (clk),
    .rst     (rst),
    .in_valid(d_valid),
    .quo     (d_quo),
    .rem     (d_rem),
    .dvs     (d_dvs),
    .in_sb   (d_sb),
    .done    (done),
    .result  (result)
  );

  // Cycles since reset, saturating once the pipeline has fully refilled.
  logic [CNT_W-1:0] since_rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      since_rst <= '0;
    end else if (since_rst != CNT_W'(LAT)) begin
      since_rst <= since_rst + 1'b1;
    end
  end

  // A miss always reports the origin.
  assert property (@(posedge clk) disable iff (rst)
    done && !result.hit |-> result.cross_x == '0 && result.cross_y == '0)
    else $error("miss beat carries a non-zero crossing point");

  // Every accepted beat comes out exactly once.
  assert property (@(posedge clk) disable iff (rst)
    since_rst == CNT_W'(LAT) |-> done == $past(accept, LAT))
    else $error("result beat does not match an accepted beat");

endmodule
`default_nettype wire

@@ sv/spi_front.sv @@
// Front pipeline: differences, cross products, numerators and magnitudes for the dividers.
`default_nettype none
module spi_front #(
  parameter int C = spi_pkg::COORD_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  input  wire spi_pkg::spi_in_t       item,
  output logic                        out_valid,
  output logic [3*C+2:0]              mag_n [2],
  output logic [2*C+2:0]              mag_d [2],
  output logic [8*C+2:0]              sb
);
  import spi_pkg::*;

  localparam int E  = C + 1;       // difference width
  localparam int P  = 2 * C;       // coordinate product width
  localparam int CW = 2 * C + 1;   // line constant width
  localparam int DM = 2 * C + 2;   // difference product width
  localparam int DW = 2 * C + 3;   // denominator width
  localparam int HP = 2 * C + 1;   // high partial product width
  localparam int LP = 2 * C + 3;   // low partial product width
  localparam int NW = 3 * C + 3;   // numerator width

  logic [FIELD_W-1:0] f [NUM_COORDS];
  logic signed [C-1:0] raw [NUM_COORDS];

  assign f[0] = item.a_start_x;
  assign f[1] = item.a_start_y;
  assign f[2] = item.a_end_x;
  assign f[3] = item.a_end_y;
  assign f[4] = item.b_start_x;
  assign f[5] = item.b_start_y;
  assign f[6] = item.b_end_x;
  assign f[7] = item.b_end_y;

  for (genvar i = 0; i < NUM_COORDS; i++) begin : g_ext
    if (C <= FIELD_W) begin : g_cut
      assign raw[i] = f[i][C-1:0];
    end else begin : g_pad
      assign raw[i] = {{(C-FIELD_W){1'b0}}, f[i]};
    end
  end

  // Stage 0: captured coordinates.
  logic                v0;
  logic signed [C-1:0] c0 [NUM_COORDS];

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else     v0 <= in_valid;
    c0 <= raw;
  end

  // Stage 1: differences, coordinate products and the point-segment selection.
  logic                v1r;
  logic signed [C-1:0] c1 [NUM_COORDS];
  logic signed [E-1:0] dx1, dy1, dx2, dy2, qdx, qdy, dax;
  logic signed [P-1:0] p12, p21, p34, p43;
  logic signed [C-1:0] ax, qy;
  logic                vert1, vert2;

  always_ff @(posedge clk) begin
    if (rst) v1r <= 1'b0;
    else     v1r <= v0;
    c1    <= c0;
    dx1   <= E'(c0[2]) - E'(c0[0]);
    dy1   <= E'(c0[3]) - E'(c0[1]);
    dx2   <= E'(c0[6]) - E'(c0[4]);
    dy2   <= E'(c0[7]) - E'(c0[5]);
    p12   <= P'(c0[0]) * P'(c0[3]);
    p21   <= P'(c0[1]) * P'(c0[2]);
    p34   <= P'(c0[4]) * P'(c0[7]);
    p43   <= P'(c0[5]) * P'(c0[6]);
    vert1 <= (c0[0] == c0[2]);
    vert2 <= (c0[4] == c0[6]);
    if (c0[0] == c0[2]) begin
      ax  <= c0[0];
      qy  <= c0[5];
      qdx <= E'(c0[6]) - E'(c0[4]);
      qdy <= E'(c0[7]) - E'(c0[5]);
      dax <= E'(c0[0]) - E'(c0[4]);
    end else begin
      ax  <= c0[4];
      qy  <= c0[1];
      qdx <= E'(c0[2]) - E'(c0[0]);
      qdy <= E'(c0[3]) - E'(c0[1]);
      dax <= E'(c0[4]) - E'(c0[0]);
    end
  end

  // Stage 2: denominator products, line constants, point-case products.
  logic                 v2r;
  logic signed [C-1:0]  c2r [NUM_COORDS];
  logic signed [E-1:0]  dx1_2, dy1_2, dx2_2, dy2_2, qdx_2;
  logic signed [DM-1:0] m1, m2;
  logic signed [CW-1:0] k1, k2;
  logic signed [DM-1:0] pt1, pt2;
  logic signed [C-1:0]  ax_2;
  logic                 vert1_2, vert2_2;

  always_ff @(posedge clk) begin
    if (rst) v2r <= 1'b0;
    else     v2r <= v1r;
    c2r     <= c1;
    dx1_2   <= dx1;
    dy1_2   <= dy1;
    dx2_2   <= dx2;
    dy2_2   <= dy2;
    qdx_2   <= qdx;
    ax_2    <= ax;
    vert1_2 <= vert1;
    vert2_2 <= vert2;
    m1      <= DM'(dx1) * DM'(dy2);
    m2      <= DM'(dy1) * DM'(dx2);
    k1      <= CW'(p12) - CW'(p21);
    k2      <= CW'(p34) - CW'(p43);
    pt1     <= DM'(qy) * DM'(qdx);
    pt2     <= DM'(qdy) * DM'(dax);
  end

  // Stage 3: the line constants are split in two halves so that each
  // multiplier stays near the coordinate width.
  logic                 v3r;
  logic signed [C-1:0]  c3r [NUM_COORDS];
  logic signed [DW-1:0] den3;
  logic signed [DM-1:0] ptn3;
  logic signed [E-1:0]  qdx_3;
  logic signed [C-1:0]  ax_3;
  logic                 vert1_3, vert2_3;
  logic signed [HP-1:0] hx1, hx2, hy1, hy2;
  logic signed [LP-1:0] lx1, lx2, ly1, ly2;
  logic signed [C-1:0]  k1_hi, k2_hi;
  logic signed [C+1:0]  k1_lo, k2_lo;

  assign k1_hi = $signed(k1[2*C:C+1]);
  assign k2_hi = $signed(k2[2*C:C+1]);
  assign k1_lo = $signed({1'b0, k1[C:0]});
  assign k2_lo = $signed({1'b0, k2[C:0]});

  always_ff @(posedge clk) begin
    if (rst) v3r <= 1'b0;
    else     v3r <= v2r;
    c3r     <= c2r;
    den3    <= DW'(m1) - DW'(m2);
    ptn3    <= pt1 + pt2;
    qdx_3   <= qdx_2;
    ax_3    <= ax_2;
    vert1_3 <= vert1_2;
    vert2_3 <= vert2_2;
    hx1     <= HP'(dx1_2) * HP'(k2_hi);
    lx1     <= LP'(dx1_2) * LP'(k2_lo);
    hx2     <= HP'(dx2_2) * HP'(k1_hi);
    lx2     <= LP'(dx2_2) * LP'(k1_lo);
    hy1     <= HP'(dy1_2) * HP'(k2_hi);
    ly1     <= LP'(dy1_2) * LP'(k2_lo);
    hy2     <= HP'(dy2_2) * HP'(k1_hi);
    ly2     <= LP'(dy2_2) * LP'(k1_lo);
  end

  // Stage 4: full numerators and the choice between the general and point cases.
  logic signed [NW-1:0] tx1, tx2, ty1, ty2;
  logic                 gen4;
  logic                 v4r, ok4;
  logic signed [C-1:0]  c4r [NUM_COORDS];
  logic signed [NW-1:0] nx4, ny4;
  logic signed [DW-1:0] dx4, dy4;

  assign tx1  = (NW'(hx1) <<< (C + 1)) + NW'(lx1);
  assign tx2  = (NW'(hx2) <<< (C + 1)) + NW'(lx2);
  assign ty1  = (NW'(hy1) <<< (C + 1)) + NW'(ly1);
  assign ty2  = (NW'(hy2) <<< (C + 1)) + NW'(ly2);
  assign gen4 = (den3 != '0);

  always_ff @(posedge clk) begin
    if (rst) v4r <= 1'b0;
    else     v4r <= v3r;
    c4r <= c3r;
    ok4 <= !(vert1_3 && vert2_3) && (gen4 || vert1_3 || vert2_3);
    if (gen4) begin
      nx4 <= tx1 - tx2;
      ny4 <= ty1 - ty2;
      dx4 <= den3;
      dy4 <= den3;
    end else begin
      nx4 <= NW'(ax_3);
      ny4 <= NW'(ptn3);
      dx4 <= DW'(1);
      dy4 <= DW'(qdx_3);
    end
  end

  // Stage 5: signs and magnitudes.
  logic [8*C-1:0] flat;

  for (genvar i = 0; i < NUM_COORDS; i++) begin : g_flat
    assign flat[i*C +: C] = c4r[i];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= v4r;
    mag_n[0] <= nx4[NW-1] ? NW'(-nx4) : NW'(nx4);
    mag_n[1] <= ny4[NW-1] ? NW'(-ny4) : NW'(ny4);
    mag_d[0] <= dx4[DW-1] ? DW'(-dx4) : DW'(dx4);
    mag_d[1] <= dy4[DW-1] ? DW'(-dy4) : DW'(dy4);
    sb       <= {ok4, nx4[NW-1] ^ dx4[DW-1], ny4[NW-1] ^ dy4[DW-1], flat};
  end

endmodule
`default_nettype wire

@@ sv/spi_div2.sv @@
// Two-lane pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module spi_div2 #(
  parameter int NW = 99,
  parameter int DW = 67,
  parameter int SW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] num [2],
  input  wire logic [DW-1:0] den [2],
  input  wire logic [SW-1:0] in_sb,
  output logic               out_valid,
  output logic [NW-1:0]      quo [2],
  output logic [DW-1:0]      rem [2],
  output logic [DW-1:0]      dvs [2],
  output logic [SW-1:0]      out_sb
);

  logic          v  [NW+1];
  logic [SW-1:0] s  [NW+1];
  logic [NW-1:0] n  [NW+1][2];
  logic [NW-1:0] q  [NW+1][2];
  logic [DW-1:0] r  [NW+1][2];
  logic [DW-1:0] d  [NW+1][2];

  assign v[0] = in_valid;
  assign s[0] = in_sb;

  for (genvar l = 0; l < 2; l++) begin : g_in
    assign n[0][l] = num[l];
    assign q[0][l] = '0;
    assign r[0][l] = '0;
    assign d[0][l] = den[l];
  end

  for (genvar k = 0; k < NW; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) v[k+1] <= 1'b0;
      else     v[k+1] <= v[k];
      s[k+1] <= s[k];
    end
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DW:0] t;
      logic        ge;
      assign t  = {r[k][l], n[k][l][NW-1]};
      assign ge = (t >= {1'b0, d[k][l]});
      always_ff @(posedge clk) begin
        r[k+1][l] <= ge ? DW'(t - {1'b0, d[k][l]}) : t[DW-1:0];
        n[k+1][l] <= n[k][l] << 1;
        q[k+1][l] <= {q[k][l][NW-2:0], ge};
        d[k+1][l] <= d[k][l];
      end
    end
  end

  assign out_valid = v[NW];
  assign out_sb    = s[NW];

  for (genvar l = 0; l < 2; l++) begin : g_out
    assign quo[l] = q[NW][l];
    assign rem[l] = r[NW][l];
    assign dvs[l] = d[NW][l];
  end

endmodule
`default_nettype wire

@@ sv/spi_back.sv @@
// Back pipeline: rounding, sign restore and the bounding box test.
`default_nettype none
module spi_back #(
  parameter int C = spi_pkg::COORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic [3*C+2:0]     quo [2],
  input  wire logic [2*C+2:0]     rem [2],
  input  wire logic [2*C+2:0]     dvs [2],
  input  wire logic [8*C+2:0]     in_sb,
  output logic                    done,
  output spi_pkg::spi_out_t       result
);
  import spi_pkg::*;

  localparam int NW = 3 * C + 3;
  localparam int DW = 2 * C + 3;
  localparam int QW = NW + 2;

  // Round stage.
  logic                 rv, rok;
  logic signed [QW-1:0] px, py;
  logic [8*C-1:0]       rflat;
  logic [NW:0]          qa, qb;

  assign qa = {1'b0, quo[0]} + {{NW{1'b0}}, ({rem[0], 1'b0} >= {1'b0, dvs[0]})};
  assign qb = {1'b0, quo[1]} + {{NW{1'b0}}, ({rem[1], 1'b0} >= {1'b0, dvs[1]})};

  always_ff @(posedge clk) begin
    if (rst) rv <= 1'b0;
    else     rv <= in_valid;
    rok   <= in_sb[8*C+2];
    px    <= in_sb[8*C+1] ? -$signed(QW'(qa)) : $signed(QW'(qa));
    py    <= in_sb[8*C]   ? -$signed(QW'(qb)) : $signed(QW'(qb));
    rflat <= in_sb[8*C-1:0];
  end

  function automatic logic in_box(input logic signed [QW-1:0] p,
                                  input logic signed [C-1:0] e1,
                                  input logic signed [C-1:0] e2);
    logic signed [QW-1:0] a, b;
    a = QW'(e1);
    b = QW'(e2);
    return (a <= b) ? (p >= a && p <= b) : (p >= b && p <= a);
  endfunction

  logic signed [C-1:0] cc [NUM_COORDS];
  logic                hit_c;
  logic [FIELD_W-1:0]  fx, fy;

  for (genvar i = 0; i < NUM_COORDS; i++) begin : g_unflat
    assign cc[i] = rflat[i*C +: C];
  end

  assign hit_c = rok && in_box(px, cc[0], cc[2]) && in_box(py, cc[1], cc[3])
                     && in_box(px, cc[4], cc[6]) && in_box(py, cc[5], cc[7]);

  if (C >= FIELD_W) begin : g_cut
    assign fx = px[FIELD_W-1:0];
    assign fy = py[FIELD_W-1:0];
  end else begin : g_pad
    assign fx = {{(FIELD_W-C){1'b0}}, px[C-1:0]};
    assign fy = {{(FIELD_W-C){1'b0}}, py[C-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= rv;
    result.hit     <= hit_c;
    result.cross_x <= hit_c ? fx : '0;
    result.cross_y <= hit_c ? fy : '0;
  end

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the segment pair intersection block.
`timescale 1ns / 100ps

module tb;
  import spi_pkg::*;

  localparam int LATENCY    = 3 * COORD_BITS_DEF + 10;
  localparam int IDLE_LIMIT = 20 * LATENCY + 2000;
  localparam int RAND_ITEMS = 800;

  // Wide enough for every product in the crossing arithmetic.
  typedef logic signed [255:0] wide_t;

  // Holds the expected crossings in issue order and compares each result
  // beat against the oldest of them.
  class crossing_scoreboard;
    spi_out_t pending[$];

    function void note_item(spi_out_t exp_res);
      pending = {pending, exp_res};
    endfunction

    // Returns a text describing the mismatch, or an empty string.
    function string check_result(spi_out_t got);
      spi_out_t exp_res;
      if (pending.size() == 0) return "result beat with nothing expected";
      exp_res = pending.pop_front();
      if (got.hit !== exp_res.hit)
        return $sformatf("hit got %0b exp %0b", got.hit, exp_res.hit);
      if (got.cross_x !== exp_res.cross_x)
        return $sformatf("cross_x got %0h exp %0h", got.cross_x, exp_res.cross_x);
      if (got.cross_y !== exp_res.cross_y)
        return $sformatf("cross_y got %0h exp %0h", got.cross_y, exp_res.cross_y);
      return "";
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  spi_in_t  item;
  logic     done;
  spi_out_t result;

  crossing_scoreboard board;
  int  n_errors;
  int  idle_cycles;
  int  send_idle_pct;

  segment_pair_intersection u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    n_errors++;
  endtask

  // Signed division rounded to nearest, halves away from zero.
  function automatic wide_t div_round(wide_t num, wide_t den);
    wide_t n_abs;
    wide_t d_abs;
    wide_t quo;
    wide_t rem;
    n_abs = (num < 0) ? -num : num;
    d_abs = (den < 0) ? -den : den;
    quo   = n_abs / d_abs;
    rem   = n_abs % d_abs;
    if (2 * rem >= d_abs) quo = quo + 1;
    return ((num < 0) != (den < 0)) ? -quo : quo;
  endfunction

  function automatic bit in_span(wide_t v, wide_t e1, wide_t e2);
    wide_t lo;
    wide_t hi;
    lo = (e1 < e2) ? e1 : e2;
    hi = (e1 < e2) ? e2 : e1;
    return v >= lo && v <= hi;
  endfunction

  // Works out the expected result beat for one pair of segments.
  function automatic spi_out_t predict_crossing(spi_in_t s);
    wide_t x1, y1, x2, y2, x3, y3, x4, y4;
    wide_t dx1, dy1, dx2, dy2, den, c1, c2, px, py;
    wide_t ax, qx, qy, qdx, qdy;
    bit vert_a, vert_b, found;
    spi_out_t r;
    x1 = wide_t'(s.a_start_x); y1 = wide_t'(s.a_start_y);
    x2 = wide_t'(s.a_end_x);   y2 = wide_t'(s.a_end_y);
    x3 = wide_t'(s.b_start_x); y3 = wide_t'(s.b_start_y);
    x4 = wide_t'(s.b_end_x);   y4 = wide_t'(s.b_end_y);
    dx1 = x2 - x1; dy1 = y2 - y1;
    dx2 = x4 - x3; dy2 = y4 - y3;
    vert_a = (dx1 == 0);
    vert_b = (dx2 == 0);
    found = 1'b0;
    px = '0;
    py = '0;
    r = '0;
    if (!(vert_a && vert_b)) begin
      den = dx1 * dy2 - dy1 * dx2;
      if (den != 0) begin
        c1 = x1 * y2 - y1 * x2;
        c2 = x3 * y4 - y3 * x4;
        px = div_round(dx1 * c2 - c1 * dx2, den);
        py = div_round(dy1 * c2 - c1 * dy2, den);
        found = 1'b1;
      end else if (vert_a || vert_b) begin
        // A point segment stands in for a vertical line through itself.
        ax  = vert_a ? x1 : x3;
        qx  = vert_a ? x3 : x1;
        qy  = vert_a ? y3 : y1;
        qdx = vert_a ? dx2 : dx1;
        qdy = vert_a ? dy2 : dy1;
        px  = ax;
        py  = div_round(qy * qdx + qdy * (ax - qx), qdx);
        found = 1'b1;
      end
    end
    if (found && in_span(px, x1, x2) && in_span(py, y1, y2) &&
        in_span(px, x3, x4) && in_span(py, y3, y4)) begin
      r.hit     = 1'b1;
      r.cross_x = px[31:0];
      r.cross_y = py[31:0];
    end
    return r;
  endfunction

  // Offers one beat and holds it until the block takes it. Start stays high
  // after the beat is taken, so the next call can follow without a gap.
  task automatic send_item(input spi_in_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item  <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_item(predict_crossing(s));
  endtask

  // A coordinate drawn from a spread of magnitudes, so that small grids,
  // fractional values and the full range all turn up.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return 32'($signed($urandom_range(20)) - 10);
      1: return 32'($signed($urandom_range(4000)) - 2000) <<< 12;
      2: return 32'($signed($urandom_range(200000)) - 100000);
      default: return $urandom;
    endcase
  endfunction

  function automatic spi_in_t rand_pair();
    spi_in_t s;
    logic [31:0] mx, my;
    s.a_start_x = rand_coord(); s.a_start_y = rand_coord();
    s.a_end_x   = rand_coord(); s.a_end_y   = rand_coord();
    s.b_start_x = rand_coord(); s.b_start_y = rand_coord();
    s.b_end_x   = rand_coord(); s.b_end_y   = rand_coord();
    case ($urandom_range(9)) inside
      0: s.b_end_x = s.b_start_x;                 // second segment vertical
      1: s.a_end_x = s.a_start_x;                 // first segment vertical
      2: begin                                    // first segment a point
        s.a_end_x = s.a_start_x;
        s.a_end_y = s.a_start_y;
      end
      3: begin                                    // parallel pair
        s.b_end_x = s.b_start_x + (s.a_end_x - s.a_start_x);
        s.b_end_y = s.b_start_y + (s.a_end_y - s.a_start_y);
      end
      [4:6]: begin
        // Both segments run through a shared point, so most of these hit.
        mx = s.a_start_x / 2 + s.a_end_x / 2;
        my = s.a_start_y / 2 + s.a_end_y / 2;
        s.b_end_x = mx + (mx - s.b_start_x);
        s.b_end_y = my + (my - s.b_start_y);
        if ($urandom_range(1)) begin
          s.b_start_x = mx - s.b_start_x[7:0];
          s.b_end_x   = mx + s.b_start_x[7:0];
        end
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic spi_in_t pair_from(int x1, int y1, int x2, int y2,
                                        int x3, int y3, int x4, int y4);
    spi_in_t s;
    s.a_start_x = x1; s.a_start_y = y1; s.a_end_x = x2; s.a_end_y = y2;
    s.b_start_x = x3; s.b_start_y = y3; s.b_end_x = x4; s.b_end_y = y4;
    return s;
  endfunction

  // Result beats cannot be held off, so every one is checked as it appears.
  always @(posedge clk) begin
    string msg;
    if (!rst && done) begin
      msg = board.check_result(result);
      if (msg != "") report_mismatch(msg);
    end
  end

  // Watchdog: counts cycles in which no beat moves either way.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int mx, mn;
    board = new();
    n_errors = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    rst   <= 1'b1;
    start <= 1'b0;
    item  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    mx = 32'h7fffffff;
    mn = 32'h80000000;
    // Directed pairs: a plain cross, a touch at an end, a near miss,
    // both vertical, parallel and collinear, point on and off a line,
    // one vertical, rounding halves, far crossings and full-range values.
    send_item(pair_from(0, 0, 65536, 65536, 0, 65536, 65536, 0));
    send_item(pair_from(0, 0, 10, 10, 10, 10, 20, 0));
    send_item(pair_from(0, 0, 10, 10, 11, 0, 20, 0));
    send_item(pair_from(5, 0, 5, 10, 5, 3, 5, 20));
    send_item(pair_from(0, 0, 10, 10, 1, 0, 11, 10));
    send_item(pair_from(0, 0, 10, 10, 5, 5, 20, 20));
    send_item(pair_from(3, 3, 3, 3, 0, 0, 10, 10));
    send_item(pair_from(3, 4, 3, 4, 0, 0, 10, 10));
    send_item(pair_from(0, 0, 10, 10, 4, 4, 4, 4));
    send_item(pair_from(4, -10, 4, 10, 0, 0, 10, 5));
    send_item(pair_from(0, 0, 3, 1, 0, 1, 3, 0));
    send_item(pair_from(0, 0, -3, -1, 0, -1, -3, 0));
    send_item(pair_from(0, 0, 1, 1, 1000, 0, 1001, 2));
    send_item(pair_from(mn, mn, mx, mx, mn, mx, mx, mn));
    send_item(pair_from(mn, 0, mx, 0, 0, mn, 0, mx));
    send_item(pair_from(mx, mx, mx, mx, mn, mn, mx, mx));
    send_item(pair_from(mn, mn, mn, mn, mn, mn, mx, mx));
    send_item(pair_from(mn, 1, mx, -1, mn, -1, mx, 1));
    send_item(pair_from(-1, -1, -1, -1, -1, -1, -1, -1));
    send_item(pair_from(0, 0, 0, 0, 0, 0, 0, 0));

    // Random part in three phases of sender idling.
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 3) send_idle_pct = 69;
      else if (i == 2 * RAND_ITEMS / 3) send_idle_pct = 0;
      else if (i < RAND_ITEMS / 3) send_idle_pct = 13;
      send_item(rand_pair());
    end
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (n_errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
